// ===== sv/mcd_pkg.sv =====
// Shared types and constants of the Moravec corner detector.
// Used by every module of the block but mcd_fifo; depends on nothing.
package mcd_pkg;

    // Geometry of the detector
    localparam int MAX_WIDTH   = 1024;
    localparam int WINDOW_SIZE = 5;
    localparam int TILE_SIZE   = 15;

    localparam int HALF_WIN   = WINDOW_SIZE / 2;
    localparam int SPAN       = 2 * HALF_WIN + 1;
    localparam int TAPS       = SPAN - 1;
    localparam int TILE_COLS  = MAX_WIDTH / TILE_SIZE;
    localparam int TILE_REACH = 2 * (TILE_SIZE / 2);
    localparam int NUM_DIRS   = 4;

    // Field and register widths
    localparam int PIX_W  = 8;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int WID_W  = 11;
    localparam int ROW_W  = 12;
    localparam int THR_W  = 18;
    localparam int STR_W  = 18;
    localparam int RM_W   = $clog2(SPAN);
    localparam int TX_W   = $clog2(MAX_WIDTH / TILE_SIZE + 1);
    localparam int OFF_W  = $clog2(TILE_SIZE);
    localparam int HB_W   = ROW_W + 1;
    localparam int WB_W   = COL_W + 1;
    localparam int SQ_W   = 2 * PIX_W;
    localparam int SUM_W  = SQ_W + $clog2(TAPS);

    localparam logic [STR_W-1:0] STR_MAX = {STR_W{1'b1}};

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 18;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_THRESHOLD    = 2'd2
    } t_cfg_idx;

    localparam logic [WID_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [ROW_W-1:0] RST_FRAME_HEIGHT = 12'd480;
    localparam logic [THR_W-1:0] RST_THRESHOLD    = 18'd975;

    // Queue depths
    localparam int PIX_QDEPTH = 4;
    localparam int RES_QDEPTH = 8;
    localparam int RCNT_W     = $clog2(RES_QDEPTH + 1);

    // Classified pixel item, front to back
    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [COL_W-1:0] col;
        logic [RM_W-1:0]  rmod;
        logic             clr;
        logic             interior;
        logic             in_tile;
        logic             last;
        logic [TX_W-1:0]  tx;
        logic [ROW_W-1:0] hc;
        logic [COL_W-1:0] wc;
    } t_pix_item;

    // Best-so-far entry of one tile column
    typedef struct packed {
        logic [STR_W-1:0] value;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
    } t_tile;

    // Keypoint result item
    typedef struct packed {
        logic [COL_W-1:0] key_x;
        logic [ROW_W-1:0] key_y;
        logic [STR_W-1:0] strength;
    } t_key;

endpackage

// ===== sv/mcd_fifo.sv =====
// Small register queue used between the detector stages.
// Standalone; no package use.
module mcd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_full,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== sv/mcd_front.sv =====
// Front end: accepts pixels, tracks raster position and tile position,
// and classifies each pixel for the back end. Uses mcd_pkg.
module mcd_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [mcd_pkg::PIX_W-1:0] i_pixel_value,
    input  logic                      i_start_of_frame,
    input  logic [mcd_pkg::WID_W-1:0] i_frame_width,
    input  logic [mcd_pkg::ROW_W-1:0] i_frame_height,
    input  logic                      i_full,
    output logic                      o_push,
    output mcd_pkg::t_pix_item        o_item
);
    localparam int COL_W = mcd_pkg::COL_W;
    localparam int WID_W = mcd_pkg::WID_W;
    localparam int ROW_W = mcd_pkg::ROW_W;
    localparam int RM_W  = mcd_pkg::RM_W;
    localparam int TX_W  = mcd_pkg::TX_W;
    localparam int OFF_W = mcd_pkg::OFF_W;
    localparam int HB_W  = mcd_pkg::HB_W;
    localparam int WB_W  = mcd_pkg::WB_W;
    localparam int HALF  = mcd_pkg::HALF_WIN;
    localparam int TILE  = mcd_pkg::TILE_SIZE;

    logic [COL_W-1:0] r_col;
    logic [ROW_W-1:0] r_row;
    logic [RM_W-1:0]  r_rmod;
    logic             r_wrap_pend;
    logic [OFF_W-1:0] r_woff, r_hoff;
    logic [TX_W-1:0]  r_wtx;
    logic [WB_W-1:0]  r_wbase;
    logic [HB_W-1:0]  r_hbase;

    logic [COL_W-1:0] n_col;
    logic [ROW_W-1:0] n_row;
    logic [RM_W-1:0]  n_rmod;
    logic             n_wrap_pend;
    logic [OFF_W-1:0] n_woff, n_hoff;
    logic [TX_W-1:0]  n_wtx;
    logic [WB_W-1:0]  n_wbase;
    logic [HB_W-1:0]  n_hbase;

    logic [WID_W-1:0] weff;
    logic [ROW_W-1:0] heff;
    logic [COL_W-1:0] c0, c1;
    logic [ROW_W-1:0] r0, r2;
    logic [ROW_W:0]   r1, rn;
    logic [WID_W-1:0] cn;
    logic [RM_W-1:0]  rm0, rm1, rm2;
    logic             wrap_c, fwrap, interior, in_tile, last;

    function automatic logic [RM_W-1:0] rm_inc(input logic [RM_W-1:0] rm);
        return (rm == RM_W'(mcd_pkg::SPAN - 1)) ? '0 : rm + 1'b1;
    endfunction

    assign o_ready = !i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        // usable frame size
        if (i_frame_width == '0) begin
            weff = WID_W'(1);
        end else if (i_frame_width > WID_W'(mcd_pkg::MAX_WIDTH)) begin
            weff = WID_W'(mcd_pkg::MAX_WIDTH);
        end else begin
            weff = i_frame_width;
        end
        heff = (i_frame_height == '0) ? ROW_W'(1) : i_frame_height;

        c0  = i_start_of_frame ? '0 : r_col;
        r0  = i_start_of_frame ? '0 : r_row;
        rm0 = i_start_of_frame ? '0 : r_rmod;

        // column beyond the width wraps to the next row
        wrap_c = ({1'b0, c0} >= weff);
        c1     = wrap_c ? '0 : c0;
        r1     = wrap_c ? {1'b0, r0} + 1'b1 : {1'b0, r0};
        rm1    = wrap_c ? rm_inc(rm0) : rm0;
        fwrap  = (r1 >= {1'b0, heff});
        r2     = fwrap ? '0 : r1[ROW_W-1:0];
        rm2    = fwrap ? '0 : rm1;

        // tile column tracking for center column c1 - HALF
        n_woff  = r_woff;
        n_wtx   = r_wtx;
        n_wbase = r_wbase;
        if (c1 == COL_W'(HALF)) begin
            n_woff  = '0;
            n_wtx   = '0;
            n_wbase = '0;
        end else if (c1 > COL_W'(HALF)) begin
            if (r_woff == OFF_W'(TILE - 1)) begin
                n_woff  = '0;
                n_wtx   = r_wtx + 1'b1;
                n_wbase = r_wbase + WB_W'(TILE);
            end else begin
                n_woff = r_woff + 1'b1;
            end
        end

        // tile row tracking for center row r2 - HALF, once per row
        n_hoff  = r_hoff;
        n_hbase = r_hbase;
        if (c1 == '0) begin
            if (r2 == ROW_W'(HALF)) begin
                n_hoff  = '0;
                n_hbase = '0;
            end else if (r2 > ROW_W'(HALF)) begin
                if (r_hoff == OFF_W'(TILE - 1)) begin
                    n_hoff  = '0;
                    n_hbase = r_hbase + HB_W'(TILE);
                end else begin
                    n_hoff = r_hoff + 1'b1;
                end
            end
        end

        interior = (c1 >= COL_W'(2 * HALF)) && (r2 >= ROW_W'(2 * HALF));
        in_tile  = interior
                && (n_hbase + HB_W'(mcd_pkg::TILE_REACH) < {1'b0, heff})
                && (n_wbase + WB_W'(mcd_pkg::TILE_REACH) < weff);
        last     = ((n_hoff == OFF_W'(TILE - 1)) || (r2 == heff - 1'b1))
                && ((n_woff == OFF_W'(TILE - 1)) || ({1'b0, c1} == weff - 1'b1));

        // position of the next pixel
        cn          = {1'b0, c1} + 1'b1;
        n_col       = c1 + 1'b1;
        n_row       = r2;
        n_rmod      = rm2;
        n_wrap_pend = 1'b0;
        rn          = {1'b0, r2} + 1'b1;
        if (cn >= weff) begin
            n_col  = '0;
            n_row  = rn[ROW_W-1:0];
            n_rmod = rm_inc(rm2);
            if (rn >= {1'b0, heff}) begin
                n_row       = '0;
                n_rmod      = '0;
                n_wrap_pend = 1'b1;
            end
        end

        o_item.pix      = i_pixel_value;
        o_item.col      = c1;
        o_item.rmod     = rm2;
        o_item.clr      = i_start_of_frame || fwrap || r_wrap_pend;
        o_item.interior = interior;
        o_item.in_tile  = in_tile;
        o_item.last     = last;
        o_item.tx       = n_wtx;
        o_item.hc       = r2 - ROW_W'(HALF);
        o_item.wc       = c1 - COL_W'(HALF);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col       <= '0;
            r_row       <= '0;
            r_rmod      <= '0;
            r_wrap_pend <= 1'b0;
            r_woff      <= '0;
            r_wtx       <= '0;
            r_wbase     <= '0;
            r_hoff      <= '0;
            r_hbase     <= '0;
        end else if (o_push) begin
            r_col       <= n_col;
            r_row       <= n_row;
            r_rmod      <= n_rmod;
            r_wrap_pend <= n_wrap_pend;
            r_woff      <= n_woff;
            r_wtx       <= n_wtx;
            r_wbase     <= n_wbase;
            r_hoff      <= n_hoff;
            r_hbase     <= n_hbase;
        end
    end

endmodule

// ===== sv/mcd_back.sv =====
// Back end: line buffer, 5x5 window, directional interest pipeline and
// per-tile maximum tracking. Uses mcd_pkg.
module mcd_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [mcd_pkg::THR_W-1:0]  i_threshold,
    input  logic                       i_avail,
    input  mcd_pkg::t_pix_item         i_item,
    output logic                       o_pop,
    input  logic [mcd_pkg::RCNT_W-1:0] i_res_count,
    output logic                       o_push,
    output mcd_pkg::t_key              o_key
);
    localparam int PIX_W = mcd_pkg::PIX_W;
    localparam int SPAN  = mcd_pkg::SPAN;
    localparam int TAPS  = mcd_pkg::TAPS;
    localparam int HALF  = mcd_pkg::HALF_WIN;
    localparam int SQ_W  = mcd_pkg::SQ_W;
    localparam int SUM_W = mcd_pkg::SUM_W;
    localparam int STR_W = mcd_pkg::STR_W;
    localparam int NDIR  = mcd_pkg::NUM_DIRS;
    localparam int CNT_W = mcd_pkg::RCNT_W;

    localparam int DIR_HORZ = 0;
    localparam int DIR_DIAG = 1;
    localparam int DIR_VERT = 2;
    localparam int DIR_ANTI = 3;

    // pipeline control
    logic                     r_v1, r_v2, r_v3, r_v4, r_v5;
    mcd_pkg::t_pix_item       r_i1, r_i2, r_i3, r_i4, r_i5;
    logic [CNT_W-1:0]         r_infl;

    // line buffer: one word per column, one byte lane per row modulo SPAN
    logic [SPAN*PIX_W-1:0]    r_lb [mcd_pkg::MAX_WIDTH];
    logic [SPAN*PIX_W-1:0]    r_lb_rd;

    logic [PIX_W-1:0]         r_win [SPAN][SPAN];
    logic [PIX_W-1:0]         new_col [SPAN];

    logic [SQ_W-1:0]          sq [NDIR][TAPS];
    logic [SQ_W-1:0]          r_sq [NDIR][TAPS];
    logic [SUM_W-1:0]         sums [NDIR];
    logic [SUM_W-1:0]         r_sum [NDIR];
    logic [SUM_W-1:0]         min_sum;
    logic [STR_W-1:0]         iv_sat, iv;
    logic [STR_W-1:0]         r_iv;

    // tile tracking
    mcd_pkg::t_tile           r_tmem [mcd_pkg::TILE_COLS];
    mcd_pkg::t_tile           r_tm_rd;
    logic [mcd_pkg::TILE_COLS-1:0] r_tvalid;
    logic                     r_fw_vld;
    logic [mcd_pkg::TX_W-1:0] r_fw_tx;
    mcd_pkg::t_tile           r_fw;
    mcd_pkg::t_tile           cur, best, wdata;
    logic                     tile_wr, emit;

    function automatic logic [SQ_W-1:0] sqd(input logic [PIX_W-1:0] a,
                                            input logic [PIX_W-1:0] b);
        logic [PIX_W-1:0] d;
        d = (a > b) ? a - b : b - a;
        return SQ_W'(d) * SQ_W'(d);
    endfunction

    // take an item only when its possible result has a reserved slot
    assign o_pop = i_avail && ((r_infl + i_res_count) < CNT_W'(mcd_pkg::RES_QDEPTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1   <= 1'b0;
            r_v2   <= 1'b0;
            r_v3   <= 1'b0;
            r_v4   <= 1'b0;
            r_v5   <= 1'b0;
            r_infl <= '0;
        end else begin
            r_v1   <= o_pop;
            r_v2   <= r_v1;
            r_v3   <= r_v2;
            r_v4   <= r_v3;
            r_v5   <= r_v4;
            r_infl <= r_infl + CNT_W'(o_pop) - CNT_W'(r_v5);
        end
    end

    always_ff @(posedge i_clk) begin
        r_i1 <= i_item;
        r_i2 <= r_i1;
        r_i3 <= r_i2;
        r_i4 <= r_i3;
        r_i5 <= r_i4;
    end

    // line buffer: write this row's lane, read the column
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_lb[i_item.col][PIX_W*int'(i_item.rmod) +: PIX_W] <= i_item.pix;
            r_lb_rd <= r_lb[i_item.col];
        end
    end

    // column in window row order, oldest row first, current pixel last
    always_comb begin
        int lane;
        for (int dy = 0; dy < SPAN; dy++) begin
            lane = int'(r_i1.rmod) + 1 + dy;
            if (lane >= SPAN) begin
                lane = lane - SPAN;
            end
            new_col[dy] = (dy == SPAN - 1) ? r_i1.pix : r_lb_rd[PIX_W*lane +: PIX_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v1) begin
            for (int dy = 0; dy < SPAN; dy++) begin
                for (int dx = 0; dx < SPAN - 1; dx++) begin
                    r_win[dy][dx] <= r_win[dy][dx+1];
                end
                r_win[dy][SPAN-1] <= new_col[dy];
            end
        end
    end

    // squared differences along the four lines through the center
    always_comb begin
        for (int t = 0; t < TAPS; t++) begin
            sq[DIR_HORZ][t] = sqd(r_win[HALF][t], r_win[HALF][t+1]);
            sq[DIR_DIAG][t] = sqd(r_win[t][t], r_win[t+1][t+1]);
            sq[DIR_VERT][t] = sqd(r_win[t][HALF], r_win[t+1][HALF]);
            sq[DIR_ANTI][t] = sqd(r_win[2*HALF-t][t], r_win[2*HALF-t-1][t+1]);
        end
    end

    always_ff @(posedge i_clk) begin
        r_sq <= sq;
    end

    always_comb begin
        for (int j = 0; j < NDIR; j++) begin
            sums[j] = '0;
            for (int t = 0; t < TAPS; t++) begin
                sums[j] = sums[j] + SUM_W'(r_sq[j][t]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_sum <= sums;
    end

    // minimum direction, saturate, threshold
    always_comb begin
        min_sum = r_sum[0];
        for (int j = 1; j < NDIR; j++) begin
            if (r_sum[j] < min_sum) begin
                min_sum = r_sum[j];
            end
        end
        iv_sat = (min_sum > SUM_W'(mcd_pkg::STR_MAX)) ? mcd_pkg::STR_MAX
                                                      : STR_W'(min_sum);
        iv     = (iv_sat <= i_threshold) ? '0 : iv_sat;
    end

    always_ff @(posedge i_clk) begin
        r_iv <= iv;
        if (r_v4) begin
            r_tm_rd <= r_tmem[r_i4.tx];
        end
    end

    // tile update; the write of the previous cycle is forwarded
    always_comb begin
        if (r_i5.clr) begin
            cur = '0;
        end else if (r_fw_vld && (r_fw_tx == r_i5.tx)) begin
            cur = r_fw;
        end else if (r_tvalid[r_i5.tx]) begin
            cur = r_tm_rd;
        end else begin
            cur = '0;
        end
        best = cur;
        if (r_iv > cur.value) begin
            best.value = r_iv;
            best.col   = r_i5.wc;
            best.row   = r_i5.hc;
        end
        tile_wr = r_v5 && r_i5.in_tile;
        emit    = tile_wr && r_i5.last && (best.value != '0);
        wdata   = r_i5.last ? '0 : best;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tvalid <= '0;
            r_fw_vld <= 1'b0;
        end else begin
            r_fw_vld <= tile_wr;
            if (r_v5 && r_i5.clr) begin
                r_tvalid <= '0;
            end
            if (tile_wr) begin
                r_tvalid[r_i5.tx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (tile_wr) begin
            r_tmem[r_i5.tx] <= wdata;
            r_fw_tx         <= r_i5.tx;
            r_fw            <= wdata;
        end
    end

    assign o_push         = emit;
    assign o_key.key_x    = best.col;
    assign o_key.key_y    = best.row;
    assign o_key.strength = best.value;

endmodule

// ===== sv/moravec_corner_detector_unit.sv =====
// Top level of the Moravec corner detector: configuration registers,
// front end, pixel queue, back end and keypoint queue. Uses mcd_pkg.
//
//  channel   direction  handshake            payload
//  pixel     in         i_valid / o_ready    i_pixel_value, i_start_of_frame
//  keypoint  out        o_valid / i_ready    o_key_x, o_key_y, o_strength
//  config    in         i_cfg_we (no wait)   i_cfg_index, i_cfg_data
//
// Throughput is one pixel item per clock while keypoint queue credit lasts;
// the back end is a 5-stage pipeline (line buffer read, window shift,
// squares, sums, min/threshold) plus the tile update that emits keypoints.
// Reset is synchronous; the line buffer has no clearing pass and the
// 68 tile entries carry valid bits cleared at once.
// The back end reserves a keypoint queue slot (8 deep) for every item in
// flight, so a stalled output may stop input before that queue fills.
module moravec_corner_detector_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [mcd_pkg::PIX_W-1:0]      i_pixel_value,
    input  logic                           i_start_of_frame,
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [mcd_pkg::COL_W-1:0]      o_key_x,
    output logic [mcd_pkg::ROW_W-1:0]      o_key_y,
    output logic [mcd_pkg::STR_W-1:0]      o_strength,
    input  logic                           i_cfg_we,
    input  logic [mcd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mcd_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    // configuration registers
    logic [mcd_pkg::WID_W-1:0] r_frame_width;
    logic [mcd_pkg::ROW_W-1:0] r_frame_height;
    logic [mcd_pkg::THR_W-1:0] r_threshold;

    // pixel queue
    logic                        pq_push, pq_pop, pq_full, pq_empty;
    mcd_pkg::t_pix_item          pq_in, pq_out;
    logic [$clog2(mcd_pkg::PIX_QDEPTH+1)-1:0] pq_count;

    // keypoint queue
    logic                        rq_push, rq_pop, rq_full, rq_empty;
    mcd_pkg::t_key               rq_in, rq_out;
    logic [mcd_pkg::RCNT_W-1:0]  rq_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= mcd_pkg::RST_FRAME_WIDTH;
            r_frame_height <= mcd_pkg::RST_FRAME_HEIGHT;
            r_threshold    <= mcd_pkg::RST_THRESHOLD;
        end else if (i_cfg_we) begin
            case (mcd_pkg::t_cfg_idx'(i_cfg_index))
                mcd_pkg::CFG_FRAME_WIDTH: begin
                    r_frame_width <= i_cfg_data[mcd_pkg::WID_W-1:0];
                end
                mcd_pkg::CFG_FRAME_HEIGHT: begin
                    r_frame_height <= i_cfg_data[mcd_pkg::ROW_W-1:0];
                end
                mcd_pkg::CFG_THRESHOLD: begin
                    r_threshold <= i_cfg_data[mcd_pkg::THR_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    mcd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_pixel_value    (i_pixel_value),
        .i_start_of_frame (i_start_of_frame),
        .i_frame_width    (r_frame_width),
        .i_frame_height   (r_frame_height),
        .i_full           (pq_full),
        .o_push           (pq_push),
        .o_item           (pq_in)
    );

    mcd_fifo #(
        .WIDTH ($bits(mcd_pkg::t_pix_item)),
        .DEPTH (mcd_pkg::PIX_QDEPTH)
    ) u_pix_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (pq_push),
        .i_data  (pq_in),
        .i_pop   (pq_pop),
        .o_data  (pq_out),
        .o_full  (pq_full),
        .o_empty (pq_empty),
        .o_count (pq_count)
    );

    mcd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_threshold (r_threshold),
        .i_avail     (!pq_empty),
        .i_item      (pq_out),
        .o_pop       (pq_pop),
        .i_res_count (rq_count),
        .o_push      (rq_push),
        .o_key       (rq_in)
    );

    mcd_fifo #(
        .WIDTH ($bits(mcd_pkg::t_key)),
        .DEPTH (mcd_pkg::RES_QDEPTH)
    ) u_key_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rq_push),
        .i_data  (rq_in),
        .i_pop   (rq_pop),
        .o_data  (rq_out),
        .o_full  (rq_full),
        .o_empty (rq_empty),
        .o_count (rq_count)
    );

    assign o_valid    = !rq_empty;
    assign rq_pop     = o_valid && i_ready;
    assign o_key_x    = rq_out.key_x;
    assign o_key_y    = rq_out.key_y;
    assign o_strength = rq_out.strength;

`ifndef SYNTH
    // credit scheme must keep the keypoint queue from overflowing
    a_key_q_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rq_push |-> !rq_full)
        else $error("keypoint queue overflow");

    // a keypoint never carries zero strength
    a_strength_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_strength != '0))
        else $error("keypoint with zero strength");

    // pixel queue pops only when something is queued
    a_pix_q_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pq_pop |-> (pq_count != '0))
        else $error("pixel queue underflow");

    // nothing is offered right after reset
    a_idle_after_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("keypoint offered out of reset");
`endif

endmodule
